>>> hdl/rlt_pkg.sv
// ----------------------------------------------------------------------------
// Recursive lock table package
// Shared widths, codes and the lock table entry type.
// ----------------------------------------------------------------------------
`default_nettype none

package rlt_pkg;

   // Table geometry.
   localparam int NUM_LOCKS  = 64;
   localparam int NUM_CORES  = 4;
   localparam int COUNT_BITS = 8;

   // Field widths fixed by the request and response formats.
   localparam int OP_W     = 2;
   localparam int LOCK_W   = 6;
   localparam int CORE_W   = 2;
   localparam int RC_W     = 2;

   // Derived widths.
   localparam int ADDR_W   = $clog2(NUM_LOCKS);
   localparam int FREE_W   = $clog2(NUM_LOCKS + 1);
   localparam int OWNER_W  = $clog2(NUM_CORES + 1);

   // Owner value of a free lock.
   localparam logic [OWNER_W-1:0] OWNER_NONE = OWNER_W'(NUM_CORES);

   // Request operations.
   typedef enum logic [OP_W-1:0] {
      OP_ACQUIRE  = 2'd0,
      OP_RELEASE  = 2'd1,
      OP_ALLOCATE = 2'd2
   } op_type;

   // Response codes.
   localparam logic [RC_W-1:0] RC_OK    = 2'd0;
   localparam logic [RC_W-1:0] RC_ERROR = 2'd1;
   localparam logic [RC_W-1:0] RC_BUSY  = 2'd2;

   // One entry of the lock table.
   typedef struct packed {
      logic [OWNER_W-1:0]    owner;
      logic [COUNT_BITS-1:0] count;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

`default_nettype wire

>>> hdl/rlt_req_if.sv
// ----------------------------------------------------------------------------
// Lock request channel
// Valid/ready channel carrying one lock request per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface rlt_req_if;
   import rlt_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [LOCK_W-1:0] lock_id;
   logic [CORE_W-1:0] core_id;

   modport source (output valid, output operation, output lock_id, output core_id,
                   input ready);
   modport sink   (input valid, input operation, input lock_id, input core_id,
                   output ready);
endinterface

`default_nettype wire

>>> hdl/rlt_rsp_if.sv
// ----------------------------------------------------------------------------
// Lock response channel
// Valid/ready channel carrying one response per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface rlt_rsp_if;
   import rlt_pkg::*;

   logic              valid;
   logic              ready;
   logic [RC_W-1:0]   result_code;
   logic [LOCK_W-1:0] new_lock_id;

   modport source (output valid, output result_code, output new_lock_id,
                   input ready);
   modport sink   (input valid, input result_code, input new_lock_id,
                   output ready);
endinterface

`default_nettype wire

>>> hdl/rlt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rlt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/recursive_lock_table.sv
// ----------------------------------------------------------------------------
// Recursive lock table
// Re-entrant locks shared by several cores with acquire, release, allocate.
// Pipeline: a request beat passes the request register and then the response
// register before its response beat is offered.
// Throughput: one request per cycle while responses are taken; the table RAM is
// read when a request is accepted and written back when that request leaves
// stage two, with a one-entry bypass.
// Reset: synchronous; clears the pipeline valids and the allocation pointer.
// The table needs no clearing pass because allocate clears each entry.
// ----------------------------------------------------------------------------
`default_nettype none

module recursive_lock_table (
   input wire logic    clock,
   input wire logic    reset,
   rlt_req_if.sink     req_chan,
   rlt_rsp_if.source   rsp_chan
);
   import rlt_pkg::*;

   // The pipeline has two registers. The request register holds an accepted
   // beat while the RAM returns its entry. The response register holds the
   // finished answer until the consumer takes it, so a new request can be
   // accepted while an answer still waits.

   logic                  s2_valid_ff, s2_valid_in;
   logic [OP_W-1:0]       s2_op_ff;
   logic [LOCK_W-1:0]     s2_lid_ff;
   logic [CORE_W-1:0]     s2_core_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RC_W-1:0]       rsp_code_ff, rsp_code_in;
   logic [LOCK_W-1:0]     rsp_id_ff, rsp_id_in;

   logic [FREE_W-1:0]     next_free_ff, next_free_in;

   // Last table write, kept so that a request read in the same cycle as that
   // write still sees the new entry.
   logic                  byp_valid_ff, byp_valid_in;
   logic [ADDR_W-1:0]     byp_addr_ff, byp_addr_in;
   entry_type             byp_data_ff, byp_data_in;

   logic                  req_beat;
   logic                  s2_adv;
   logic [ENTRY_W-1:0]    ram_rdata;
   entry_type             cur;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   entry_type             wr_data;
   logic                  id_ok;
   logic                  owner_match;

   // Stage two moves on when the response register is empty or being drained.
   assign s2_adv         = s2_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s2_valid_ff || s2_adv;
   assign req_beat       = req_chan.valid && req_chan.ready;

   rlt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_LOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (req_beat),
      .rd_addr (req_chan.lock_id[ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   // Current entry of the addressed lock, with the bypass applied.
   always_comb begin
      if (byp_valid_ff && (byp_addr_ff == s2_lid_ff[ADDR_W-1:0])) begin
         cur = byp_data_ff;
      end else begin
         cur = entry_type'(ram_rdata);
      end
   end

   // A lock index is usable once allocated, and only from a real core.
   assign id_ok = (FREE_W'(s2_lid_ff) < next_free_ff) &&
                  (FREE_W'(s2_lid_ff) < FREE_W'(NUM_LOCKS)) &&
                  (OWNER_W'(s2_core_ff) < OWNER_W'(NUM_CORES));
   assign owner_match = (cur.owner == OWNER_W'(s2_core_ff));

   // Decision logic for the request in stage two. Nothing is written unless
   // stage two actually advances.
   always_comb begin
      wr_en        = 1'b0;
      wr_addr      = s2_lid_ff[ADDR_W-1:0];
      wr_data      = cur;
      rsp_code_in  = RC_ERROR;
      rsp_id_in    = '0;
      next_free_in = next_free_ff;

      case (s2_op_ff)
         OP_ACQUIRE: begin
            if (id_ok) begin
               if (owner_match) begin
                  // Nested acquire; saturating count answers error.
                  if (cur.count != '1) begin
                     wr_en         = 1'b1;
                     wr_data.count = cur.count + 1'b1;
                     rsp_code_in   = RC_OK;
                  end
               end else if (cur.owner == OWNER_NONE) begin
                  wr_en         = 1'b1;
                  wr_data.owner = OWNER_W'(s2_core_ff);
                  wr_data.count = COUNT_BITS'(1);
                  rsp_code_in   = RC_OK;
               end else begin
                  rsp_code_in = RC_BUSY;
               end
            end
         end
         OP_RELEASE: begin
            if (id_ok && owner_match) begin
               wr_en       = 1'b1;
               rsp_code_in = RC_OK;
               if (cur.count <= COUNT_BITS'(1)) begin
                  wr_data.owner = OWNER_NONE;
                  wr_data.count = '0;
               end else begin
                  wr_data.count = cur.count - 1'b1;
               end
            end
         end
         OP_ALLOCATE: begin
            if (next_free_ff < FREE_W'(NUM_LOCKS)) begin
               wr_en         = 1'b1;
               wr_addr       = next_free_ff[ADDR_W-1:0];
               wr_data.owner = OWNER_NONE;
               wr_data.count = '0;
               rsp_code_in   = RC_OK;
               rsp_id_in     = LOCK_W'(next_free_ff);
               next_free_in  = next_free_ff + 1'b1;
            end
         end
         default: begin
            // Unknown operation answers error and changes nothing.
         end
      endcase

      if (!s2_adv) begin
         wr_en        = 1'b0;
         next_free_in = next_free_ff;
      end
   end

   // The bypass tracks the write of the request just ahead of the one that
   // will next sit in stage two, so it only changes when stage two advances.
   always_comb begin
      byp_valid_in = byp_valid_ff;
      byp_addr_in  = byp_addr_ff;
      byp_data_in  = byp_data_ff;
      if (s2_adv) begin
         byp_valid_in = wr_en;
         byp_addr_in  = wr_addr;
         byp_data_in  = wr_data;
      end
   end

   always_comb begin
      if (req_beat) begin
         s2_valid_in = 1'b1;
      end else if (s2_adv) begin
         s2_valid_in = 1'b0;
      end else begin
         s2_valid_in = s2_valid_ff;
      end

      if (s2_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         byp_valid_ff <= 1'b0;
         next_free_ff <= '0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         byp_valid_ff <= byp_valid_in;
         next_free_ff <= next_free_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_beat) begin
         s2_op_ff   <= req_chan.operation;
         s2_lid_ff  <= req_chan.lock_id;
         s2_core_ff <= req_chan.core_id;
      end
      if (s2_adv) begin
         rsp_code_ff <= rsp_code_in;
         rsp_id_ff   <= rsp_id_in;
      end
      byp_addr_ff <= byp_addr_in;
      byp_data_ff <= byp_data_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.result_code = rsp_code_ff;
   assign rsp_chan.new_lock_id = rsp_id_ff;

endmodule

`default_nettype wire
